### hdl/geodetic_pair_to_ned_offset_defines.svh
// ---------------------------------------------------------------------------
// geodetic_pair_to_ned_offset_defines
// Assertion macros used by the gpn_chk checker file of this block.
// ---------------------------------------------------------------------------
`ifndef GEODETIC_PAIR_TO_NED_OFFSET_DEFINES_SVH
`define GEODETIC_PAIR_TO_NED_OFFSET_DEFINES_SVH

// same-cycle implication, clocked on clk, off while rst_n is low
`define GPN_ASSERT_IMP(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("gpn: same-cycle check failed");

// next-cycle implication
`define GPN_ASSERT_NXT(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("gpn: next-cycle check failed");

`endif

### hdl/gpn_pkg.sv
// ---------------------------------------------------------------------------
// gpn_pkg
// Fixed-point constants and the CORDIC arctangent table for the geodetic
// pair to NED offset datapath.
// ---------------------------------------------------------------------------
`default_nettype none

package gpn_pkg;

  typedef logic signed [63:0] q60_t;

  localparam q60_t ONE_Q60        = 64'sh1000_0000_0000_0000;
  localparam q60_t THREE_Q60      = 64'sh3000_0000_0000_0000;
  localparam q60_t PI_Q60         = 64'sh3243_F6A8_885A_308D;
  localparam q60_t HALF_PI_Q60    = 64'sh1921_FB54_442D_1847;
  localparam q60_t QUARTER_PI_Q60 = 64'sh0C90_FDAA_2216_8C23;
  localparam q60_t GAIN_Q60       = 64'sd700114967507362826;
  localparam q60_t E2_Q60         = 64'sd7718094650622875;
  localparam q60_t ONE_M_E2_Q60   = ONE_Q60 - E2_Q60;
  localparam q60_t RE_MM_Q16      = 64'sd417997586327470;
  localparam q60_t OUT_LIMIT      = 64'sd20000000000;
  localparam q60_t ROUND_MM       = 64'sd32768;

  // multiplier latency, fixed by the two-stage partial-product unit
  localparam int ML = 2;
  // ECEF unit timing, counted from its input
  localparam int NWT_ITERS   = 5;
  localparam int NWT_START   = 2 * ML + 1;
  localparam int RN_LAT      = NWT_START + NWT_ITERS * (3 * ML + 1) + ML;
  localparam int ECEF_LAT    = RN_LAT + 2 * ML + 1;

  function automatic logic [63:0] odd_div(input logic [63:0] t, input int k);
    logic [63:0] q;
    case (k)
      0:  q = t;
      1:  q = t / 64'd3;
      2:  q = t / 64'd5;
      3:  q = t / 64'd7;
      4:  q = t / 64'd9;
      5:  q = t / 64'd11;
      6:  q = t / 64'd13;
      7:  q = t / 64'd15;
      8:  q = t / 64'd17;
      9:  q = t / 64'd19;
      10: q = t / 64'd21;
      11: q = t / 64'd23;
      12: q = t / 64'd25;
      13: q = t / 64'd27;
      14: q = t / 64'd29;
      15: q = t / 64'd31;
      16: q = t / 64'd33;
      17: q = t / 64'd35;
      18: q = t / 64'd37;
      19: q = t / 64'd39;
      20: q = t / 64'd41;
      21: q = t / 64'd43;
      22: q = t / 64'd45;
      23: q = t / 64'd47;
      24: q = t / 64'd49;
      25: q = t / 64'd51;
      26: q = t / 64'd53;
      27: q = t / 64'd55;
      28: q = t / 64'd57;
      29: q = t / 64'd59;
      default: q = t;
    endcase
    return q;
  endfunction

  // atan(2^-i) in Q60 by the truncated Taylor series
  function automatic q60_t atan_q60(input int i);
    q60_t        sum;
    logic [63:0] t;
    int          e;
    sum = '0;
    if (i == 0) return QUARTER_PI_Q60;
    for (int k = 0; k < 30; k++) begin
      e = i * (2 * k + 1);
      if (e <= 60) begin
        t = odd_div(64'd1 << (60 - e), k);
        sum = ((k & 1) == 1) ? sum - $signed(t) : sum + $signed(t);
      end
    end
    return sum;
  endfunction

endpackage

`default_nettype wire

### hdl/gpn_dly.sv
// ---------------------------------------------------------------------------
// gpn_dly
// Enabled shift line that carries side data alongside the pipeline.
// ---------------------------------------------------------------------------
`default_nettype none

module gpn_dly #(
  parameter int W = 64,
  parameter int N = 1
) (
  input  wire logic         clk,
  input  wire logic         en,
  input  wire logic [W-1:0] d,
  output logic      [W-1:0] q
);
  logic [W-1:0] d_r [N];

  always_ff @(posedge clk) begin
    if (en) begin
      d_r[0] <= d;
      for (int i = 1; i < N; i++) begin
        d_r[i] <= d_r[i-1];
      end
    end
  end

  assign q = d_r[N-1];
endmodule

`default_nettype wire

### hdl/gpn_mulsh.sv
// ---------------------------------------------------------------------------
// gpn_mulsh
// 64x64 signed multiply, rounded shift right by SH, saturated magnitude.
// Four 32x32 partial products, then combine, round and sign.
// ---------------------------------------------------------------------------
`default_nettype none

module gpn_mulsh #(
  parameter int SH = 60
) (
  input  wire logic                clk,
  input  wire logic                en,
  input  wire gpn_pkg::q60_t       a,
  input  wire gpn_pkg::q60_t       b,
  output gpn_pkg::q60_t            p
);
  import gpn_pkg::*;

  localparam logic [127:0] RND = 128'd1 << (SH - 1);

  logic [63:0]  ua, ub;
  logic         neg_r;
  logic [63:0]  p00_r, p01_r, p10_r, p11_r;
  logic [127:0] sum, qf;
  logic [63:0]  q;
  logic         sat;
  q60_t         p_r;

  assign ua = a[63] ? 64'(-a) : 64'(a);
  assign ub = b[63] ? 64'(-b) : 64'(b);

  always_ff @(posedge clk) begin
    if (en) begin
      neg_r <= a[63] ^ b[63];
      p00_r <= ua[31:0]  * ub[31:0];
      p01_r <= ua[31:0]  * ub[63:32];
      p10_r <= ua[63:32] * ub[31:0];
      p11_r <= ua[63:32] * ub[63:32];
    end
  end

  always_comb begin
    sum = {p11_r, 64'd0} + {32'd0, p01_r, 32'd0} + {32'd0, p10_r, 32'd0}
        + {64'd0, p00_r} + RND;
    qf  = sum >> SH;
    sat = |qf[127:63];
    q   = sat ? 64'h7FFF_FFFF_FFFF_FFFF : qf[63:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= neg_r ? $signed(~q + 64'd1) : $signed(q);
    end
  end

  assign p = p_r;
endmodule

`default_nettype wire

### hdl/gpn_cordic.sv
// ---------------------------------------------------------------------------
// gpn_cordic
// Pipelined rotation-mode CORDIC: one rotation per stage, angle folded
// into +-pi/2 first.
// ---------------------------------------------------------------------------
`default_nettype none

module gpn_cordic #(
  parameter int STAGES = 32
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire gpn_pkg::q60_t z,
  output gpn_pkg::q60_t      c,
  output gpn_pkg::q60_t      s
);
  import gpn_pkg::*;

  q60_t x_r [STAGES+1];
  q60_t y_r [STAGES+1];
  q60_t z_r [STAGES+1];
  logic f_r [STAGES+1];
  q60_t c_r, s_r;

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= GAIN_Q60;
      y_r[0] <= '0;
      if (z > HALF_PI_Q60) begin
        z_r[0] <= z - PI_Q60;
        f_r[0] <= 1'b1;
      end else if (z < -HALF_PI_Q60) begin
        z_r[0] <= z + PI_Q60;
        f_r[0] <= 1'b1;
      end else begin
        z_r[0] <= z;
        f_r[0] <= 1'b0;
      end
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_rot
    localparam q60_t AT = atan_q60(i);
    always_ff @(posedge clk) begin
      if (en) begin
        f_r[i+1] <= f_r[i];
        if (!z_r[i][63]) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - AT;
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + AT;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_r <= f_r[STAGES] ? -x_r[STAGES] : x_r[STAGES];
      s_r <= f_r[STAGES] ? -y_r[STAGES] : y_r[STAGES];
    end
  end

  assign c = c_r;
  assign s = s_r;
endmodule

`default_nettype wire

### hdl/gpn_ecef.sv
// ---------------------------------------------------------------------------
// gpn_ecef
// Geodetic to ECEF (mm Q16). Prime-vertical radius from five pipelined
// Newton steps for 1/sqrt(1 - e2 sin^2).
// ---------------------------------------------------------------------------
`default_nettype none

module gpn_ecef (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire gpn_pkg::q60_t      sl,
  input  wire gpn_pkg::q60_t      cl,
  input  wire gpn_pkg::q60_t      so,
  input  wire gpn_pkg::q60_t      co,
  input  wire logic signed [27:0] h,
  output gpn_pkg::q60_t           ex,
  output gpn_pkg::q60_t           ey,
  output gpn_pkg::q60_t           ez
);
  import gpn_pkg::*;

  q60_t s2, es, t_r;
  q60_t r_s [NWT_ITERS+1];
  q60_t t_s [NWT_ITERS+1];
  q60_t rn, a_r, w, b, c_r;
  q60_t sl_d, cl_d, so_d, co_d;
  logic [27:0] h_a, h_c;
  q60_t hq_a, hq_c;

  gpn_mulsh #(.SH(60)) u_s2 (.clk, .en, .a(sl), .b(sl), .p(s2));
  gpn_mulsh #(.SH(60)) u_es (.clk, .en, .a(E2_Q60), .b(s2), .p(es));

  always_ff @(posedge clk) begin
    if (en) begin
      t_r <= ONE_Q60 - es;
    end
  end

  assign r_s[0] = ONE_Q60;
  assign t_s[0] = t_r;

  // r <- r * (3 - t r^2) / 2
  for (genvar j = 0; j < NWT_ITERS; j++) begin : g_nwt
    q60_t rr, td, ty2, rd, u_r;
    gpn_mulsh #(.SH(60)) u_rr (.clk, .en, .a(r_s[j]), .b(r_s[j]), .p(rr));
    gpn_dly #(.W(64), .N(ML)) u_td (.clk, .en, .d(t_s[j]), .q(td));
    gpn_mulsh #(.SH(60)) u_ty (.clk, .en, .a(td), .b(rr), .p(ty2));
    always_ff @(posedge clk) begin
      if (en) begin
        u_r <= THREE_Q60 - ty2;
      end
    end
    gpn_dly #(.W(64), .N(2 * ML + 1)) u_rd (.clk, .en, .d(r_s[j]), .q(rd));
    gpn_mulsh #(.SH(61)) u_rn (.clk, .en, .a(rd), .b(u_r), .p(r_s[j+1]));
    gpn_dly #(.W(64), .N(3 * ML + 1)) u_tn (.clk, .en, .d(t_s[j]), .q(t_s[j+1]));
  end

  gpn_mulsh #(.SH(60)) u_rnm (.clk, .en, .a(RE_MM_Q16), .b(r_s[NWT_ITERS]), .p(rn));

  gpn_dly #(.W(28), .N(RN_LAT))          u_dh_a (.clk, .en, .d(h), .q(h_a));
  gpn_dly #(.W(28), .N(RN_LAT + ML))     u_dh_c (.clk, .en, .d(h), .q(h_c));
  gpn_dly #(.W(64), .N(RN_LAT + 1))      u_dcl  (.clk, .en, .d(cl), .q(cl_d));
  gpn_dly #(.W(64), .N(RN_LAT + ML + 1)) u_dsl  (.clk, .en, .d(sl), .q(sl_d));
  gpn_dly #(.W(64), .N(RN_LAT + ML + 1)) u_dso  (.clk, .en, .d(so), .q(so_d));
  gpn_dly #(.W(64), .N(RN_LAT + ML + 1)) u_dco  (.clk, .en, .d(co), .q(co_d));

  assign hq_a = {{20{h_a[27]}}, h_a, 16'd0};
  assign hq_c = {{20{h_c[27]}}, h_c, 16'd0};

  always_ff @(posedge clk) begin
    if (en) begin
      a_r <= rn + hq_a;
      c_r <= b + hq_c;
    end
  end

  gpn_mulsh #(.SH(60)) u_w  (.clk, .en, .a(a_r), .b(cl_d), .p(w));
  gpn_mulsh #(.SH(60)) u_b  (.clk, .en, .a(rn), .b(ONE_M_E2_Q60), .p(b));
  gpn_mulsh #(.SH(60)) u_ex (.clk, .en, .a(w), .b(co_d), .p(ex));
  gpn_mulsh #(.SH(60)) u_ey (.clk, .en, .a(w), .b(so_d), .p(ey));
  gpn_mulsh #(.SH(60)) u_ez (.clk, .en, .a(c_r), .b(sl_d), .p(ez));
endmodule

`default_nettype wire

### hdl/geodetic_pair_to_ned_offset.sv
// ---------------------------------------------------------------------------
// geodetic_pair_to_ned_offset
// Two WGS-84 geodetic points to the NED offset of the second from the first.
// ---------------------------------------------------------------------------
// Fully pipelined: one position pair is taken every cycle while in_stall
// is low. The latency is set by the CORDIC rotation stages, the five Newton
// steps of the inverse square root and the 64-bit multipliers chained
// behind them. A two-entry output stage (output register plus skid
// register) lets the block keep taking words while a result waits;
// in_stall rises only once both entries are full and the whole pipeline
// holds. No clearing pass after reset.
`default_nettype none

module geodetic_pair_to_ned_offset #(
  parameter int CORDIC_STAGES = 32
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [30:0] in_lat_a,
  input  wire logic signed [31:0] in_lon_a,
  input  wire logic signed [27:0] in_height_a,
  input  wire logic signed [30:0] in_lat_b,
  input  wire logic signed [31:0] in_lon_b,
  input  wire logic signed [27:0] in_height_b,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [35:0]      out_north,
  output logic signed [35:0]      out_east,
  output logic signed [35:0]      out_down
);
  import gpn_pkg::*;

  localparam int CL  = CORDIC_STAGES + 2;
  localparam int LAT = CL + ECEF_LAT + ML + 3;

  logic en;
  logic [LAT-1:0] v_r;
  q60_t za_lat, za_lon, zb_lat, zb_lon;
  q60_t cla, sla, coa, soa, clb, slb, cob, sob;
  logic [27:0] ha_d, hb_d;
  q60_t ea0, ea1, ea2, eb0, eb1, eb2;
  q60_t p1, p2, p3, p4, p1d, p2d, p3d, p4d;
  q60_t clbd, slbd, sobd, cobd;
  q60_t dx_r, dy_r, dz_r;
  q60_t m1, m2, m3, m4, m5, m6, m7, m8;
  q60_t n_r, e_r, d_r;
  q60_t nm, em, dm;
  logic signed [35:0] fn_r, fe_r, fd_r;
  logic signed [35:0] sk_n_r, sk_e_r, sk_d_r;
  logic signed [35:0] on_r, oe_r, od_r;
  logic out_valid_r, skid_full_r, push, out_take;

  assign en       = !skid_full_r;
  assign in_stall = skid_full_r;

  assign za_lat = {{2{in_lat_a[30]}}, in_lat_a, 31'd0};
  assign za_lon = {in_lon_a[31], in_lon_a, 31'd0};
  assign zb_lat = {{2{in_lat_b[30]}}, in_lat_b, 31'd0};
  assign zb_lon = {in_lon_b[31], in_lon_b, 31'd0};

  gpn_cordic #(.STAGES(CORDIC_STAGES)) u_cla (.clk, .en, .z(za_lat), .c(cla), .s(sla));
  gpn_cordic #(.STAGES(CORDIC_STAGES)) u_coa (.clk, .en, .z(za_lon), .c(coa), .s(soa));
  gpn_cordic #(.STAGES(CORDIC_STAGES)) u_clb (.clk, .en, .z(zb_lat), .c(clb), .s(slb));
  gpn_cordic #(.STAGES(CORDIC_STAGES)) u_cob (.clk, .en, .z(zb_lon), .c(cob), .s(sob));

  gpn_dly #(.W(28), .N(CL)) u_dha (.clk, .en, .d(in_height_a), .q(ha_d));
  gpn_dly #(.W(28), .N(CL)) u_dhb (.clk, .en, .d(in_height_b), .q(hb_d));

  gpn_ecef u_ea (.clk, .en, .sl(sla), .cl(cla), .so(soa), .co(coa), .h(ha_d),
                 .ex(ea0), .ey(ea1), .ez(ea2));
  gpn_ecef u_eb (.clk, .en, .sl(slb), .cl(clb), .so(sob), .co(cob), .h(hb_d),
                 .ex(eb0), .ey(eb1), .ez(eb2));

  // rotation terms at the target point
  gpn_mulsh #(.SH(60)) u_p1 (.clk, .en, .a(slb), .b(cob), .p(p1));
  gpn_mulsh #(.SH(60)) u_p2 (.clk, .en, .a(slb), .b(sob), .p(p2));
  gpn_mulsh #(.SH(60)) u_p3 (.clk, .en, .a(clb), .b(cob), .p(p3));
  gpn_mulsh #(.SH(60)) u_p4 (.clk, .en, .a(clb), .b(sob), .p(p4));

  gpn_dly #(.W(64), .N(ECEF_LAT + 1 - ML)) u_dp1 (.clk, .en, .d(p1), .q(p1d));
  gpn_dly #(.W(64), .N(ECEF_LAT + 1 - ML)) u_dp2 (.clk, .en, .d(p2), .q(p2d));
  gpn_dly #(.W(64), .N(ECEF_LAT + 1 - ML)) u_dp3 (.clk, .en, .d(p3), .q(p3d));
  gpn_dly #(.W(64), .N(ECEF_LAT + 1 - ML)) u_dp4 (.clk, .en, .d(p4), .q(p4d));
  gpn_dly #(.W(64), .N(ECEF_LAT + 1)) u_dclb (.clk, .en, .d(clb), .q(clbd));
  gpn_dly #(.W(64), .N(ECEF_LAT + 1)) u_dslb (.clk, .en, .d(slb), .q(slbd));
  gpn_dly #(.W(64), .N(ECEF_LAT + 1)) u_dsob (.clk, .en, .d(sob), .q(sobd));
  gpn_dly #(.W(64), .N(ECEF_LAT + 1)) u_dcob (.clk, .en, .d(cob), .q(cobd));

  always_ff @(posedge clk) begin
    if (en) begin
      dx_r <= eb0 - ea0;
      dy_r <= eb1 - ea1;
      dz_r <= eb2 - ea2;
    end
  end

  gpn_mulsh #(.SH(60)) u_m1 (.clk, .en, .a(dx_r), .b(p1d),  .p(m1));
  gpn_mulsh #(.SH(60)) u_m2 (.clk, .en, .a(dy_r), .b(p2d),  .p(m2));
  gpn_mulsh #(.SH(60)) u_m3 (.clk, .en, .a(dz_r), .b(clbd), .p(m3));
  gpn_mulsh #(.SH(60)) u_m4 (.clk, .en, .a(dx_r), .b(sobd), .p(m4));
  gpn_mulsh #(.SH(60)) u_m5 (.clk, .en, .a(dy_r), .b(cobd), .p(m5));
  gpn_mulsh #(.SH(60)) u_m6 (.clk, .en, .a(dx_r), .b(p3d),  .p(m6));
  gpn_mulsh #(.SH(60)) u_m7 (.clk, .en, .a(dy_r), .b(p4d),  .p(m7));
  gpn_mulsh #(.SH(60)) u_m8 (.clk, .en, .a(dz_r), .b(slbd), .p(m8));

  always_ff @(posedge clk) begin
    if (en) begin
      n_r <= m3 - m1 - m2;
      e_r <= m5 - m4;
      d_r <= -m6 - m7 - m8;
    end
  end

  // mm Q16 to mm, ties toward +inf, then clamp
  assign nm = (n_r + ROUND_MM) >>> 16;
  assign em = (e_r + ROUND_MM) >>> 16;
  assign dm = (d_r + ROUND_MM) >>> 16;

  always_ff @(posedge clk) begin
    if (en) begin
      fn_r <= (nm > OUT_LIMIT) ? OUT_LIMIT[35:0] :
              (nm < -OUT_LIMIT) ? 36'(-OUT_LIMIT) : nm[35:0];
      fe_r <= (em > OUT_LIMIT) ? OUT_LIMIT[35:0] :
              (em < -OUT_LIMIT) ? 36'(-OUT_LIMIT) : em[35:0];
      fd_r <= (dm > OUT_LIMIT) ? OUT_LIMIT[35:0] :
              (dm < -OUT_LIMIT) ? 36'(-OUT_LIMIT) : dm[35:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[LAT-2:0], in_valid};
    end
  end

  assign push     = v_r[LAT-1] && en;
  assign out_take = out_valid_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_full_r <= 1'b0;
    end else if (!out_valid_r || out_take) begin
      if (skid_full_r) begin
        on_r        <= sk_n_r;
        oe_r        <= sk_e_r;
        od_r        <= sk_d_r;
        out_valid_r <= 1'b1;
        skid_full_r <= 1'b0;
      end else begin
        out_valid_r <= push;
        if (push) begin
          on_r <= fn_r;
          oe_r <= fe_r;
          od_r <= fd_r;
        end
      end
    end else if (push) begin
      sk_n_r      <= fn_r;
      sk_e_r      <= fe_r;
      sk_d_r      <= fd_r;
      skid_full_r <= 1'b1;
    end
  end

  assign out_valid = out_valid_r;
  assign out_north = on_r;
  assign out_east  = oe_r;
  assign out_down  = od_r;
endmodule

`default_nettype wire

### hdl/gpn_chk.sv
// ---------------------------------------------------------------------------
// gpn_chk
// Port-level checks for geodetic_pair_to_ned_offset, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none
`include "geodetic_pair_to_ned_offset_defines.svh"

module gpn_chk (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire logic signed [30:0] in_lat_a,
  input wire logic signed [31:0] in_lon_a,
  input wire logic signed [27:0] in_height_a,
  input wire logic signed [30:0] in_lat_b,
  input wire logic signed [31:0] in_lon_b,
  input wire logic signed [27:0] in_height_b,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic signed [35:0] out_north,
  input wire logic signed [35:0] out_east,
  input wire logic signed [35:0] out_down
);
  // a held word stays put
  `GPN_ASSERT_NXT(a_hold, out_valid && out_stall, out_valid && $stable(out_north) && $stable(out_east) && $stable(out_down))
  // north and down results stay inside the clamp
  `GPN_ASSERT_IMP(a_range, out_valid, out_north <= 36'sd20000000000 && out_north >= -36'sd20000000000 && out_down <= 36'sd20000000000 && out_down >= -36'sd20000000000)
  // input backpressure only follows a held output word
  `GPN_ASSERT_IMP(a_stall_on, $rose(in_stall), $past(out_valid && out_stall))
  // skid drains only when the output word is taken
  `GPN_ASSERT_IMP(a_stall_off, $fell(in_stall), $past(out_valid && !out_stall))
endmodule

bind geodetic_pair_to_ned_offset gpn_chk u_gpn_chk (.*);

`default_nettype wire

### test/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for geodetic_pair_to_ned_offset: position pairs go in
// through a random-gap driver, an internal fixed-point predictor computes
// the NED offset for every accepted word, and a monitor under random
// back-pressure compares each result word against the oldest prediction.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import gpn_pkg::*;

  localparam int STAGES   = 32;
  localparam int WD_LIMIT = 5000;
  localparam int N_RAND   = 950;
  localparam longint LAT_MAX = 843314857;
  localparam longint LON_MAX = 1686629713;
  localparam longint H_MAX   = 100000000;
  localparam longint I64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;

  typedef struct {
    logic signed [30:0] lat_a;
    logic signed [31:0] lon_a;
    logic signed [27:0] height_a;
    logic signed [30:0] lat_b;
    logic signed [31:0] lon_b;
    logic signed [27:0] height_b;
    int                 gap;
    bit                 drain;
  } pair_t;

  typedef struct {
    logic [35:0] north;
    logic [35:0] east;
    logic [35:0] down;
  } ned_t;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall;
  logic signed [30:0] in_lat_a, in_lat_b;
  logic signed [31:0] in_lon_a, in_lon_b;
  logic signed [27:0] in_height_a, in_height_b;
  logic signed [35:0] out_north, out_east, out_down;

  geodetic_pair_to_ned_offset #(.CORDIC_STAGES(STAGES)) dut (.*);

  pair_t  pending_q[$];
  ned_t   ned_q[$];
  longint atan_q[STAGES];
  int     n_err, idle_cycles, n_out;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report(input string what, input logic [35:0] got, input logic [35:0] want);
    $display("ERROR %s: got %0d expected %0d", what, $signed(got), $signed(want));
    n_err++;
  endtask

  // rounded (a*b) >> sh on magnitudes, saturating to the int64 limit
  function automatic longint mul_rnd(input longint a, input longint b, input int sh);
    logic [127:0] ua, ub, p;
    logic         neg;
    neg = (a < 0) != (b < 0);
    ua = a < 0 ? 128'd0 - {{64{1'b1}}, a} : {64'd0, a};
    ub = b < 0 ? 128'd0 - {{64{1'b1}}, b} : {64'd0, b};
    p = (ua * ub + (128'd1 << (sh - 1))) >> sh;
    if (p > 128'(I64_MAX)) p = 128'(I64_MAX);
    return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
  endfunction

  task automatic sin_cos(input longint z_in, output longint c, output longint s);
    longint x, y, z, dx, dy;
    bit     flip;
    x = GAIN_Q60; y = 0; z = z_in; flip = 0;
    if (z > HALF_PI_Q60) begin
      z -= PI_Q60; flip = 1;
    end else if (z < -HALF_PI_Q60) begin
      z += PI_Q60; flip = 1;
    end
    for (int i = 0; i < STAGES; i++) begin
      dx = y >>> i; dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_q[i];
      end else begin
        x += dx; y -= dy; z += atan_q[i];
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  // ECEF position in mm Q16
  task automatic ecef(input longint sl, cl, so, co, h, output longint p[3]);
    longint t, r, rn, hq, w;
    t = ONE_Q60 - mul_rnd(E2_Q60, mul_rnd(sl, sl, 60), 60);
    r = ONE_Q60;
    hq = h * 65536;
    for (int n = 0; n < 5; n++)
      r = mul_rnd(r, 3 * ONE_Q60 - mul_rnd(t, mul_rnd(r, r, 60), 60), 61);
    rn = mul_rnd(RE_MM_Q16, r, 60);
    w = mul_rnd(rn + hq, cl, 60);
    p[0] = mul_rnd(w, co, 60);
    p[1] = mul_rnd(w, so, 60);
    p[2] = mul_rnd(mul_rnd(rn, ONE_Q60 - E2_Q60, 60) + hq, sl, 60);
  endtask

  function automatic logic [35:0] to_mm(input longint v);
    longint m;
    m = (v + 32768) >>> 16;
    if (m > OUT_LIMIT) m = OUT_LIMIT;
    if (m < -OUT_LIMIT) m = -OUT_LIMIT;
    return m[35:0];
  endfunction

  task automatic predict_ned(input pair_t it, output ned_t r);
    longint cla, sla, coa, soa, clb, slb, cob, sob, dx, dy, dz;
    longint pa[3], pb[3];
    sin_cos(longint'(it.lat_a) <<< 31, cla, sla);
    sin_cos(longint'(it.lon_a) <<< 31, coa, soa);
    sin_cos(longint'(it.lat_b) <<< 31, clb, slb);
    sin_cos(longint'(it.lon_b) <<< 31, cob, sob);
    ecef(sla, cla, soa, coa, longint'(it.height_a), pa);
    ecef(slb, clb, sob, cob, longint'(it.height_b), pb);
    dx = pb[0] - pa[0]; dy = pb[1] - pa[1]; dz = pb[2] - pa[2];
    r.north = to_mm(-mul_rnd(dx, mul_rnd(slb, cob, 60), 60)
                    - mul_rnd(dy, mul_rnd(slb, sob, 60), 60) + mul_rnd(dz, clb, 60));
    r.east  = to_mm(-mul_rnd(dx, sob, 60) + mul_rnd(dy, cob, 60));
    r.down  = to_mm(-mul_rnd(dx, mul_rnd(clb, cob, 60), 60)
                    - mul_rnd(dy, mul_rnd(clb, sob, 60), 60) - mul_rnd(dz, slb, 60));
  endtask

  function automatic longint rnd_in(input longint lim);
    return longint'($urandom_range(0, 32'(2 * lim))) - lim;
  endfunction

  task automatic add_pair(input longint la, oa, ha, lb, ob, hb, input int gap);
    pair_t it;
    it.lat_a = la[30:0]; it.lon_a = oa[31:0]; it.height_a = ha[27:0];
    it.lat_b = lb[30:0]; it.lon_b = ob[31:0]; it.height_b = hb[27:0];
    it.gap = gap; it.drain = 0;
    pending_q.push_back(it);
  endtask

  // driver
  int    gap_cnt;
  pair_t cur;
  always @(posedge clk) begin
    logic take;
    logic nxt_valid;
    ned_t pred;
    if (!rst_n) begin
      in_valid <= 1'b0; gap_cnt = 0;
      {in_lat_a, in_lon_a, in_height_a, in_lat_b, in_lon_b, in_height_b} <= '0;
    end else begin
      take = in_valid && !in_stall;
      nxt_valid = in_valid && !take;
      if (take) begin
        predict_ned(cur, pred);
        ned_q.push_back(pred);
      end
      if (!nxt_valid) begin
        if (gap_cnt > 0) gap_cnt--;
        else if (pending_q.size() != 0 &&
                 !(pending_q[0].drain && (ned_q.size() != 0 || take))) begin
          if (pending_q[0].gap > 0 && !pending_q[0].drain) begin
            gap_cnt = pending_q[0].gap - 1;
            pending_q[0].gap = 0;
          end else begin
            cur = pending_q.pop_front();
            nxt_valid = 1'b1;
            in_lat_a <= cur.lat_a; in_lon_a <= cur.lon_a; in_height_a <= cur.height_a;
            in_lat_b <= cur.lat_b; in_lon_b <= cur.lon_b; in_height_b <= cur.height_b;
          end
        end
      end
      in_valid <= nxt_valid;
    end
  end

  // monitor and receiver back-pressure
  int stall_cnt;
  always @(posedge clk) begin
    ned_t w;
    if (!rst_n) begin
      out_stall <= 1'b0; stall_cnt = 0; n_out = 0;
    end else begin
      if (out_valid && !out_stall) begin
        n_out++;
        if (ned_q.size() == 0) begin
          $display("ERROR result word with nothing expected");
          n_err++;
        end else begin
          w = ned_q.pop_front();
          if (out_north !== w.north) report("north", out_north, w.north);
          if (out_east !== w.east) report("east", out_east, w.east);
          if (out_down !== w.down) report("down", out_down, w.down);
        end
        // every third hundred words runs without back-pressure
        stall_cnt = ((n_out / 100) % 3 == 1) ? 0 : $urandom_range(0, 8);
      end else if (stall_cnt > 0) stall_cnt--;
      out_stall <= (stall_cnt > 0);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else if (idle_cycles >= WD_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    longint big[2];
    n_err = 0; idle_cycles = 0;
    rst_n = 1'b0; in_valid = 1'b0; out_stall = 1'b0;
    for (int i = 0; i < STAGES; i++) begin
      atan_q[i] = 0;
      if (i == 0) atan_q[i] = QUARTER_PI_Q60;
      else
        for (int k = 0; i * (2 * k + 1) <= 60; k++)
          atan_q[i] += ((k & 1) ? -1 : 1) *
                       longint'((64'd1 << (60 - i * (2 * k + 1))) / (2 * k + 1));
    end

    // directed: zeros, identical points, range extremes, full-code extremes
    add_pair(0, 0, 0, 0, 0, 0, 0);
    add_pair(12345678, -9876543, 5000, 12345678, -9876543, 5000, 0);
    add_pair(LAT_MAX, LON_MAX, H_MAX, -LAT_MAX, -LON_MAX, -H_MAX, 0);
    add_pair(-LAT_MAX, -LON_MAX, -H_MAX, LAT_MAX, LON_MAX, H_MAX, 1);
    add_pair(LAT_MAX, 0, 0, LAT_MAX, LON_MAX, 0, 0);
    add_pair(-LAT_MAX, 0, 0, -LAT_MAX, -LON_MAX, 0, 0);
    add_pair(0, LON_MAX, 0, 0, -LON_MAX, 0, 2);
    add_pair(0, 0, -H_MAX, 0, 0, H_MAX, 0);
    add_pair(0, 0, H_MAX, LAT_MAX, LON_MAX, -H_MAX, 0);
    // codes beyond +-pi/2 take the flipped CORDIC path
    add_pair(-(1 << 30), -(64'sd1 << 31), -(1 << 27), (1 << 30) - 1, (64'sd1 << 31) - 1,
             (1 << 27) - 1, 0);
    add_pair((1 << 30) - 1, (64'sd1 << 31) - 1, (1 << 27) - 1, -(1 << 30),
             -(64'sd1 << 31), -(1 << 27), 3);
    add_pair(LAT_MAX + 1, LON_MAX + 1, H_MAX + 1, -LAT_MAX - 1, -LON_MAX - 1, -H_MAX - 1, 0);
    add_pair(0, 0, 0, 0, 64'sd843314857, 0, 0);
    add_pair(843314857, 64'sd843314857, 0, -843314857, -64'sd843314857, 0, 0);
    add_pair(1, -1, 1, -1, 1, -1, 0);
    pending_q[$].drain = 1;

    for (int n = 0; n < N_RAND; n++) begin
      int g;
      g = ((n / 80) % 4 == 2) ? 0 : $urandom_range(0, 8);
      if ($urandom_range(0, 9) == 0)
        add_pair($signed(31'($urandom)), $signed($urandom), $signed(28'($urandom)),
                 $signed(31'($urandom)), $signed($urandom), $signed(28'($urandom)), g);
      else if ($urandom_range(0, 3) == 0) begin
        // nearby pair: small offsets around a random point
        big[0] = rnd_in(LAT_MAX - 200000); big[1] = rnd_in(LON_MAX - 200000);
        add_pair(big[0], big[1], rnd_in(H_MAX / 2), big[0] + rnd_in(100000),
                 big[1] + rnd_in(100000), rnd_in(H_MAX / 2), g);
      end else
        add_pair(rnd_in(LAT_MAX), rnd_in(LON_MAX), rnd_in(H_MAX),
                 rnd_in(LAT_MAX), rnd_in(LON_MAX), rnd_in(H_MAX), g);
      if (n == N_RAND / 2) pending_q[$].drain = 1;
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_q.size() == 0 && !in_valid && ned_q.size() == 0);
    repeat (STAGES + 200) @(posedge clk);
    if (n_err == 0 && ned_q.size() == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

`default_nettype wire
